### rtl/mbx_pkg.sv
// shared constants and types of the message mailbox block
`default_nettype none

package mbx_pkg;

    // sizing
    localparam int MAILBOXES = 16;
    localparam int SLOTS     = 32;
    localparam int BOX_W     = $clog2(MAILBOXES);
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int STAMP_W   = 32;

    // action codes
    localparam logic [1:0] ACT_SEND       = 2'd0;
    localparam logic [1:0] ACT_RECV_NAMED = 2'd1;
    localparam logic [1:0] ACT_RECV_ANY   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_BOX = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // request item
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  box;
        logic [7:0]  peer;
        logic [31:0] handle;
    } req_t;

    // response item
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] got_handle;
        logic [7:0]  got_sender;
    } rsp_t;

    // one stored message
    typedef struct packed {
        logic [BOX_W-1:0]   box;
        logic [7:0]         sender;
        logic [31:0]        handle;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    // write port of the slot memory
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_t             data;
    } slot_wr_t;

endpackage

`default_nettype wire

### rtl/mbx_req_if.sv
// request channel: valid, ready and one request item
`default_nettype none

interface mbx_req_if;
    logic          valid;
    logic          ready;
    mbx_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/mbx_rsp_if.sv
// response channel: valid, ready and one response item
`default_nettype none

interface mbx_rsp_if;
    logic          valid;
    logic          ready;
    mbx_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/mbx_slot_ram.sv
// slot memory: one write port, one registered read port
`default_nettype none

module mbx_slot_ram (
    input  wire logic                            clk,
    input  wire mbx_pkg::slot_wr_t               wr,
    input  wire logic                            rd_en,
    input  wire logic [mbx_pkg::SLOT_W-1:0]      rd_addr,
    output mbx_pkg::slot_t                       rd_data
);

    mbx_pkg::slot_t mem_reg [mbx_pkg::SLOTS];
    mbx_pkg::slot_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.data;
        end
    end

    // read port, registered while rd_en is high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/mailbox_selective_receive_top.sv
// top level of the message mailbox block with sender filter
//
// Messages for all mailboxes share one pool of slots held in a synchronous
// memory; a bank of used flags marks the occupied slots. One item is worked
// on at a time. A send walks the used flags from slot 0 and stores into the
// first free slot. A receive reads every slot of the memory once, one per
// cycle through its single read port, and keeps the newest match. Unused
// actions and out-of-range mailboxes answer without a walk or a scan. A new
// request is taken while the previous result still waits in the output
// register.
`default_nettype none

module mailbox_selective_receive_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mbx_req_if.sink    req,
    mbx_rsp_if.source  rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_RECV,
        S_DRAIN,
        S_PICK,
        S_FINISH
    } state_t;

    localparam logic [mbx_pkg::SLOT_W-1:0] LAST_SLOT = mbx_pkg::SLOT_W'(mbx_pkg::SLOTS - 1);

    state_t                         state_reg;
    mbx_pkg::req_t                  cur_reg;
    logic [mbx_pkg::SLOTS-1:0]      used_reg;
    logic [mbx_pkg::STAMP_W-1:0]    next_stamp_reg;
    logic [mbx_pkg::SLOT_W-1:0]     scan_idx_reg;

    // compare stage of the receive scan
    logic                           chk_valid_reg;
    logic [mbx_pkg::SLOT_W-1:0]     chk_idx_reg;
    logic                           found_reg;
    logic [mbx_pkg::SLOT_W-1:0]     best_idx_reg;
    logic [mbx_pkg::STAMP_W-1:0]    best_age_reg;
    logic [31:0]                    best_handle_reg;
    logic [7:0]                     best_sender_reg;

    // pending and delivered result
    mbx_pkg::rsp_t                  res_reg;
    mbx_pkg::rsp_t                  out_reg;
    logic                           out_valid_reg;

    mbx_pkg::slot_wr_t              slot_wr;
    mbx_pkg::slot_t                 rd_data;
    logic                           req_xfer;
    logic                           bad_box;
    logic                           chk_hit;
    logic [mbx_pkg::STAMP_W-1:0]    age;

    mbx_slot_ram u_ram (
        .clk     (clk),
        .wr      (slot_wr),
        .rd_en   (state_reg == S_RECV),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign bad_box = ({1'b0, req.payload.box} >= 9'(mbx_pkg::MAILBOXES));

    // store into the free slot found by the send walk
    always_comb
    begin
        slot_wr.en          = (state_reg == S_SEND) && !used_reg[scan_idx_reg];
        slot_wr.addr        = scan_idx_reg;
        slot_wr.data.box    = cur_reg.box[mbx_pkg::BOX_W-1:0];
        slot_wr.data.sender = cur_reg.peer;
        slot_wr.data.handle = cur_reg.handle;
        slot_wr.data.stamp  = next_stamp_reg;
    end

    // match and age check of the slot just read
    always_comb
    begin
        age     = next_stamp_reg - rd_data.stamp;
        chk_hit = chk_valid_reg && used_reg[chk_idx_reg]
                  && (rd_data.box == cur_reg.box[mbx_pkg::BOX_W-1:0])
                  && ((cur_reg.action != mbx_pkg::ACT_RECV_NAMED)
                      || (rd_data.sender == cur_reg.peer))
                  && (!found_reg || (age < best_age_reg));
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cur_reg         <= '0;
            used_reg        <= '0;
            next_stamp_reg  <= '0;
            scan_idx_reg    <= '0;
            chk_valid_reg   <= 1'b0;
            chk_idx_reg     <= '0;
            found_reg       <= 1'b0;
            best_idx_reg    <= '0;
            best_age_reg    <= '0;
            best_handle_reg <= '0;
            best_sender_reg <= '0;
            res_reg         <= '0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // output register drains on a transfer unless refilled below
            if (out_valid_reg && rsp.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            // compare stage works on the slot read in the cycle before
            chk_valid_reg <= (state_reg == S_RECV);
            chk_idx_reg   <= scan_idx_reg;
            if (chk_hit)
            begin
                found_reg       <= 1'b1;
                best_idx_reg    <= chk_idx_reg;
                best_age_reg    <= age;
                best_handle_reg <= rd_data.handle;
                best_sender_reg <= rd_data.sender;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        cur_reg      <= req.payload;
                        scan_idx_reg <= '0;
                        found_reg    <= 1'b0;
                        priority if (req.payload.action != mbx_pkg::ACT_SEND
                                     && req.payload.action != mbx_pkg::ACT_RECV_NAMED
                                     && req.payload.action != mbx_pkg::ACT_RECV_ANY)
                        begin
                            res_reg.status <= mbx_pkg::ST_NONE;
                            state_reg      <= S_FINISH;
                        end
                        else if (bad_box)
                        begin
                            res_reg.status <= mbx_pkg::ST_BAD_BOX;
                            state_reg      <= S_FINISH;
                        end
                        else if (req.payload.action == mbx_pkg::ACT_SEND)
                        begin
                            state_reg <= S_SEND;
                        end
                        else
                        begin
                            state_reg <= S_RECV;
                        end
                    end
                end

                S_SEND:
                begin
                    priority if (!used_reg[scan_idx_reg])
                    begin
                        used_reg[scan_idx_reg] <= 1'b1;
                        next_stamp_reg         <= next_stamp_reg + 1'b1;
                        res_reg.status         <= mbx_pkg::ST_OK;
                        state_reg              <= S_FINISH;
                    end
                    else if (scan_idx_reg == LAST_SLOT)
                    begin
                        res_reg.status <= mbx_pkg::ST_FULL;
                        state_reg      <= S_FINISH;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                S_RECV:
                begin
                    if (scan_idx_reg == LAST_SLOT)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                // last slot is compared in this cycle
                S_DRAIN:
                begin
                    state_reg <= S_PICK;
                end

                // remove the newest match, or report that none was found
                S_PICK:
                begin
                    if (found_reg)
                    begin
                        used_reg[best_idx_reg] <= 1'b0;
                        res_reg.status         <= mbx_pkg::ST_OK;
                        res_reg.got_handle     <= best_handle_reg;
                        res_reg.got_sender     <= best_sender_reg;
                    end
                    else
                    begin
                        res_reg.status <= mbx_pkg::ST_NONE;
                    end
                    state_reg <= S_FINISH;
                end

                // hand the result to the output register once it is free
                S_FINISH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        res_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
